/* hdl/ltuv_pkg.sv */
// Shared constants, payload types and arithmetic helpers for the lat/lon to unit vector block.
package ltuv_pkg;

	// Number formats.
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int OUT_FRAC_BITS   = 30;
	localparam int ROTATION_STAGES = 32;
	localparam int WORK_BITS       = 60;
	localparam int TAB_LEN         = 61;
	localparam int ROT_STAGES      = (ROTATION_STAGES < TAB_LEN) ? ROTATION_STAGES : TAB_LEN;

	// Field and datapath widths.
	localparam int LON_W    = 25;
	localparam int LAT_W    = 24;
	localparam int VEC_W    = 32;
	localparam int DEG_W    = LON_W - 1;
	localparam int WORK_W   = 63;
	localparam int RAD_W    = WORK_W - 1;
	localparam int MAG_W    = 62;
	localparam int HALF_W   = MAG_W / 2;
	localparam int PP_W     = 2 * HALF_W;
	localparam int PROD_W   = 2 * MAG_W;
	localparam int DEG_SPLIT = 30;
	localparam int HI_W     = 25;
	localparam int LO_W     = DEG_SPLIT;
	localparam int HI_P_W   = DEG_W + HI_W;
	localparam int LO_P_W   = DEG_W + LO_W;
	localparam int RAD_SH   = DEG_SPLIT - ANGLE_FRAC_BITS;
	localparam int RND_SH   = WORK_BITS - OUT_FRAC_BITS;

	// Degrees to radians, split into two partial factors.
	localparam logic [63:0]     DEG_RAD_Q60 = 64'd20122276272436452;
	localparam logic [HI_W-1:0] DEG_RAD_HI  = HI_W'(DEG_RAD_Q60 >> DEG_SPLIT);
	localparam logic [LO_W-1:0] DEG_RAD_LO  = LO_W'(DEG_RAD_Q60);

	// Angle limits in degrees.
	localparam logic [LON_W-1:0] LON_LIM = LON_W'(180 << ANGLE_FRAC_BITS);
	localparam logic [LAT_W-1:0] LAT_LIM = LAT_W'(90 << ANGLE_FRAC_BITS);

	// Radian constants and the rotation start vector.
	localparam logic signed [WORK_W-1:0] PI_Q60       = 63'sd3622009729038561421;
	localparam logic signed [WORK_W-1:0] HALF_PI      = PI_Q60 / 2;
	localparam logic signed [WORK_W-1:0] QUARTER_PI   = PI_Q60 / 4;
	localparam logic signed [WORK_W-1:0] INV_GAIN_Q60 = 63'sd700114967507363238;

	// Payloads.
	typedef struct packed {
		logic signed [LON_W-1:0] longitude_angle;
		logic signed [LAT_W-1:0] latitude_angle;
	} angle_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] vec_x;
		logic signed [VEC_W-1:0] vec_y;
		logic signed [VEC_W-1:0] vec_z;
	} vec_t;

	// One rotation stage holds both angles side by side.
	typedef struct packed {
		logic                     flip;
		logic signed [WORK_W-1:0] lat_x;
		logic signed [WORK_W-1:0] lat_y;
		logic signed [WORK_W-1:0] lat_z;
		logic signed [WORK_W-1:0] lon_x;
		logic signed [WORK_W-1:0] lon_y;
		logic signed [WORK_W-1:0] lon_z;
	} rot_t;

	typedef struct packed {
		logic                     valid;
		logic                     flip;
		logic signed [WORK_W-1:0] lat;
		logic signed [WORK_W-1:0] lon;
	} cordic_in_t;

	typedef struct packed {
		logic                     valid;
		logic                     flip;
		logic signed [WORK_W-1:0] cos_lat;
		logic signed [WORK_W-1:0] sin_lat;
		logic signed [WORK_W-1:0] cos_lon;
		logic signed [WORK_W-1:0] sin_lon;
	} cordic_out_t;

	typedef logic [ROT_STAGES-1:0][WORK_W-1:0] arc_tab_t;

	// Division of a power of two by a small odd divisor, used only while building the table.
	function automatic logic [63:0] odd_div(input logic [63:0] v, input int k);
		logic [63:0] q;
		case (k)
			1:  q = v;
			3:  q = v / 3;
			5:  q = v / 5;
			7:  q = v / 7;
			9:  q = v / 9;
			11: q = v / 11;
			13: q = v / 13;
			15: q = v / 15;
			17: q = v / 17;
			19: q = v / 19;
			21: q = v / 21;
			23: q = v / 23;
			25: q = v / 25;
			27: q = v / 27;
			29: q = v / 29;
			31: q = v / 31;
			33: q = v / 33;
			35: q = v / 35;
			37: q = v / 37;
			39: q = v / 39;
			41: q = v / 41;
			43: q = v / 43;
			45: q = v / 45;
			47: q = v / 47;
			49: q = v / 49;
			51: q = v / 51;
			53: q = v / 53;
			55: q = v / 55;
			57: q = v / 57;
			59: q = v / 59;
			default: q = '0;
		endcase
		return q;
	endfunction

	// Arctangent of 2^-i as a truncated power series; the first entry is a quarter of pi.
	function automatic logic signed [WORK_W-1:0] arc_entry(input int i);
		logic signed [63:0] acc;
		logic [63:0]        term;
		acc = '0;
		if (i == 0) begin
			acc = 64'(QUARTER_PI);
		end else begin
			for (int k = 1; k < TAB_LEN; k += 2) begin
				if (i * k <= WORK_BITS) begin
					term = odd_div(64'd1 << (WORK_BITS - i * k), k);
					if (k[1]) begin
						acc = acc - $signed(term);
					end else begin
						acc = acc + $signed(term);
					end
				end
			end
		end
		return WORK_W'(acc);
	endfunction

	function automatic arc_tab_t build_arc_tab();
		arc_tab_t t;
		for (int i = 0; i < ROT_STAGES; i++) begin
			t[i] = arc_entry(i);
		end
		return t;
	endfunction

	localparam arc_tab_t ARC_TAB = build_arc_tab();

	// One micro-rotation of both vectors, steered by the sign of the residual angle.
	function automatic rot_t rot_step(input rot_t r, input int i);
		rot_t                     n;
		logic signed [WORK_W-1:0] a;
		a = $signed(ARC_TAB[i]);
		n.flip = r.flip;
		if (!r.lat_z[WORK_W-1]) begin
			n.lat_x = r.lat_x - ($signed(r.lat_y) >>> i);
			n.lat_y = r.lat_y + ($signed(r.lat_x) >>> i);
			n.lat_z = r.lat_z - a;
		end else begin
			n.lat_x = r.lat_x + ($signed(r.lat_y) >>> i);
			n.lat_y = r.lat_y - ($signed(r.lat_x) >>> i);
			n.lat_z = r.lat_z + a;
		end
		if (!r.lon_z[WORK_W-1]) begin
			n.lon_x = r.lon_x - ($signed(r.lon_y) >>> i);
			n.lon_y = r.lon_y + ($signed(r.lon_x) >>> i);
			n.lon_z = r.lon_z - a;
		end else begin
			n.lon_x = r.lon_x + ($signed(r.lon_y) >>> i);
			n.lon_y = r.lon_y - ($signed(r.lon_x) >>> i);
			n.lon_z = r.lon_z + a;
		end
		return n;
	endfunction

	// Round half away from zero to the output format, saturate at one and apply the sign.
	function automatic logic [VEC_W-1:0] to_vec(input logic [WORK_W-1:0] u, input logic neg);
		logic [WORK_W:0] sum;
		logic [WORK_W:0] rnd;
		logic [WORK_W:0] res;
		sum = (WORK_W+1)'(u) + ((WORK_W+1)'(1) << (RND_SH - 1));
		rnd = sum >> RND_SH;
		if (rnd > ((WORK_W+1)'(1) << OUT_FRAC_BITS)) begin
			rnd = (WORK_W+1)'(1) << OUT_FRAC_BITS;
		end
		res = neg ? -rnd : rnd;
		return VEC_W'(res);
	endfunction

endpackage

/* hdl/ltuv_cordic.sv */
// Pipelined CORDIC rotator that turns a latitude and a longitude into cosine and sine.
module ltuv_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  ltuv_pkg::cordic_in_t  start,
	output ltuv_pkg::cordic_out_t result
);
	import ltuv_pkg::*;

	rot_t                  seed;
	rot_t                  rot_s [ROT_STAGES];
	logic [ROT_STAGES-1:0] vld_s;

	// Both rotations start from the inverse gain on the x axis.
	always_comb begin
		seed.flip  = start.flip;
		seed.lat_x = INV_GAIN_Q60;
		seed.lat_y = '0;
		seed.lat_z = start.lat;
		seed.lon_x = INV_GAIN_Q60;
		seed.lon_y = '0;
		seed.lon_z = start.lon;
	end

	// Valid bits move with the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[ROT_STAGES-2:0], start.valid};
		end
	end

	// One micro-rotation per register stage.
	always_ff @(posedge clk) begin
		if (en) begin
			rot_s[0] <= rot_step(seed, 0);
			for (int i = 1; i < ROT_STAGES; i++) begin
				rot_s[i] <= rot_step(rot_s[i-1], i);
			end
		end
	end

	// Final stage outputs.
	always_comb begin
		result.valid   = vld_s[ROT_STAGES-1];
		result.flip    = rot_s[ROT_STAGES-1].flip;
		result.cos_lat = rot_s[ROT_STAGES-1].lat_x;
		result.sin_lat = rot_s[ROT_STAGES-1].lat_y;
		result.cos_lon = rot_s[ROT_STAGES-1].lon_x;
		result.sin_lon = rot_s[ROT_STAGES-1].lon_y;
	end

endmodule

/* hdl/latlon_to_unit_vector.sv */
// Top level: latitude and longitude in degrees to a Cartesian unit vector.
// The block takes one request per clock cycle while angle_ready is high and returns
// x = cos(lat)cos(lon), y = cos(lat)sin(lon) and z = sin(lat): the input stages turn
// degrees into radians and fold the longitude into a quarter turn, 32 CORDIC rotation
// stages (one per cycle unless stalled, both angles in parallel) give the cosines and
// sines, and the output stages form the products from 31-bit halves and round them to
// 30 fraction bits. Angles beyond the valid range are clamped, and results are
// saturated to plus or minus one. A two-entry output buffer (output stage plus one
// holding register) lets the block keep taking requests while a result waits;
// angle_ready drops only while that holding register is full.
module latlon_to_unit_vector (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             angle_valid,
	output logic             angle_ready,
	input  ltuv_pkg::angle_t angle,
	output logic             vec_valid,
	input  logic             vec_ready,
	output ltuv_pkg::vec_t   vec
);
	import ltuv_pkg::*;

	logic en;

	// Stage 1 signals.
	logic [LON_W-1:0] lon_abs;
	logic [LON_W-1:0] lon_clamp;
	logic [LAT_W-1:0] lat_abs;
	logic [LAT_W-1:0] lat_clamp;
	logic             vld_s1;
	logic             lon_neg_s1;
	logic             lat_neg_s1;
	logic [DEG_W-1:0] lon_mag_s1;
	logic [DEG_W-1:0] lat_mag_s1;

	// Stage 2 signals.
	logic              vld_s2;
	logic              lon_neg_s2;
	logic              lat_neg_s2;
	logic [HI_P_W-1:0] lon_hi_s2;
	logic [LO_P_W-1:0] lon_lo_s2;
	logic [HI_P_W-1:0] lat_hi_s2;
	logic [LO_P_W-1:0] lat_lo_s2;

	// Stage 3 signals.
	logic [RAD_W-1:0]         lon_r;
	logic [RAD_W-1:0]         lat_r;
	logic                     vld_s3;
	logic signed [WORK_W-1:0] lon_s3;
	logic signed [WORK_W-1:0] lat_s3;

	// Stage 4 signals.
	logic signed [WORK_W-1:0] lon_fold;
	logic                     flip;
	logic                     vld_s4;
	logic                     flip_s4;
	logic signed [WORK_W-1:0] lon_s4;
	logic signed [WORK_W-1:0] lat_s4;

	// Rotator.
	cordic_in_t  rot_start;
	cordic_out_t rot_res;

	// Stage 5 signals.
	logic [WORK_W-1:0] cl_abs;
	logic [WORK_W-1:0] co_abs;
	logic [WORK_W-1:0] so_abs;
	logic [WORK_W-1:0] sl_abs;
	logic              co_neg;
	logic              so_neg;
	logic              vld_s5;
	logic              x_neg_s5;
	logic              y_neg_s5;
	logic              z_neg_s5;
	logic [MAG_W-1:0]  cl_mag_s5;
	logic [MAG_W-1:0]  co_mag_s5;
	logic [MAG_W-1:0]  so_mag_s5;
	logic [WORK_W-1:0] z_mag_s5;

	// Stage 6 to 8 signals.
	logic              vld_s6;
	logic              x_neg_s6;
	logic              y_neg_s6;
	logic              z_neg_s6;
	logic [PP_W-1:0]   x_pp_s6 [4];
	logic [PP_W-1:0]   y_pp_s6 [4];
	logic [WORK_W-1:0] z_mag_s6;
	logic              vld_s7;
	logic              x_neg_s7;
	logic              y_neg_s7;
	logic              z_neg_s7;
	logic [PP_W-1:0]   x_lo_s7;
	logic [PP_W:0]     x_mid_s7;
	logic [PP_W-1:0]   x_hi_s7;
	logic [PP_W-1:0]   y_lo_s7;
	logic [PP_W:0]     y_mid_s7;
	logic [PP_W-1:0]   y_hi_s7;
	logic [WORK_W-1:0] z_mag_s7;
	logic [PROD_W-1:0] x_full;
	logic [PROD_W-1:0] y_full;
	logic              vld_s8;
	logic              x_neg_s8;
	logic              y_neg_s8;
	logic              z_neg_s8;
	logic [WORK_W-1:0] x_mag_s8;
	logic [WORK_W-1:0] y_mag_s8;
	logic [WORK_W-1:0] z_mag_s8;

	// Stage 9 and output buffer.
	logic vld_s9;
	vec_t vec_s9;
	logic skid_vld_q;
	vec_t skid_q;

	// The whole pipeline advances unless the holding register is occupied.
	assign en          = !skid_vld_q;
	assign angle_ready = en;

	// Stage 1: magnitude and sign of each angle, clamped to its range.
	always_comb begin
		lon_abs   = angle.longitude_angle[LON_W-1] ? LON_W'(-angle.longitude_angle)
			: LON_W'(angle.longitude_angle);
		lon_clamp = (lon_abs > LON_LIM) ? LON_LIM : lon_abs;
		lat_abs   = angle.latitude_angle[LAT_W-1] ? LAT_W'(-angle.latitude_angle)
			: LAT_W'(angle.latitude_angle);
		lat_clamp = (lat_abs > LAT_LIM) ? LAT_LIM : lat_abs;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lon_neg_s1 <= angle.longitude_angle[LON_W-1];
			lat_neg_s1 <= angle.latitude_angle[LAT_W-1];
			lon_mag_s1 <= DEG_W'(lon_clamp);
			lat_mag_s1 <= DEG_W'(lat_clamp);
		end
	end

	// Stage 2: degrees times the radian factor, in a high and a low part.
	always_ff @(posedge clk) begin
		if (en) begin
			lon_neg_s2 <= lon_neg_s1;
			lat_neg_s2 <= lat_neg_s1;
			lon_hi_s2  <= HI_P_W'(lon_mag_s1) * HI_P_W'(DEG_RAD_HI);
			lon_lo_s2  <= LO_P_W'(lon_mag_s1) * LO_P_W'(DEG_RAD_LO);
			lat_hi_s2  <= HI_P_W'(lat_mag_s1) * HI_P_W'(DEG_RAD_HI);
			lat_lo_s2  <= LO_P_W'(lat_mag_s1) * LO_P_W'(DEG_RAD_LO);
		end
	end

	// Stage 3: combine the partial products into a signed radian angle.
	always_comb begin
		lon_r = (RAD_W'(lon_hi_s2) << RAD_SH) + RAD_W'(lon_lo_s2 >> ANGLE_FRAC_BITS);
		lat_r = (RAD_W'(lat_hi_s2) << RAD_SH) + RAD_W'(lat_lo_s2 >> ANGLE_FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lon_s3 <= lon_neg_s2 ? -$signed({1'b0, lon_r}) : $signed({1'b0, lon_r});
			lat_s3 <= lat_neg_s2 ? -$signed({1'b0, lat_r}) : $signed({1'b0, lat_r});
		end
	end

	// Stage 4: bring a longitude beyond a quarter turn back by half a turn.
	always_comb begin
		lon_fold = lon_s3;
		flip     = 1'b0;
		if (lon_s3 > HALF_PI) begin
			lon_fold = lon_s3 - PI_Q60;
			flip     = 1'b1;
		end else if (lon_s3 < -HALF_PI) begin
			lon_fold = lon_s3 + PI_Q60;
			flip     = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flip_s4 <= flip;
			lon_s4  <= lon_fold;
			lat_s4  <= lat_s3;
		end
	end

	// CORDIC rotation stages sit between stage 4 and stage 5.
	always_comb begin
		rot_start.valid = vld_s4;
		rot_start.flip  = flip_s4;
		rot_start.lat   = lat_s4;
		rot_start.lon   = lon_s4;
	end

	ltuv_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.start  (rot_start),
		.result (rot_res)
	);

	// Stage 5: magnitudes and product signs; a fold negates the longitude terms.
	always_comb begin
		cl_abs = rot_res.cos_lat[WORK_W-1] ? WORK_W'(-rot_res.cos_lat) : WORK_W'(rot_res.cos_lat);
		co_abs = rot_res.cos_lon[WORK_W-1] ? WORK_W'(-rot_res.cos_lon) : WORK_W'(rot_res.cos_lon);
		so_abs = rot_res.sin_lon[WORK_W-1] ? WORK_W'(-rot_res.sin_lon) : WORK_W'(rot_res.sin_lon);
		sl_abs = rot_res.sin_lat[WORK_W-1] ? WORK_W'(-rot_res.sin_lat) : WORK_W'(rot_res.sin_lat);
		co_neg = rot_res.flip ? (!rot_res.cos_lon[WORK_W-1] && (rot_res.cos_lon != '0))
			: rot_res.cos_lon[WORK_W-1];
		so_neg = rot_res.flip ? (!rot_res.sin_lon[WORK_W-1] && (rot_res.sin_lon != '0))
			: rot_res.sin_lon[WORK_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_neg_s5  <= rot_res.cos_lat[WORK_W-1] ^ co_neg;
			y_neg_s5  <= rot_res.cos_lat[WORK_W-1] ^ so_neg;
			z_neg_s5  <= rot_res.sin_lat[WORK_W-1];
			cl_mag_s5 <= MAG_W'(cl_abs);
			co_mag_s5 <= MAG_W'(co_abs);
			so_mag_s5 <= MAG_W'(so_abs);
			z_mag_s5  <= sl_abs;
		end
	end

	// Stage 6: four half-width partial products for each of x and y.
	always_ff @(posedge clk) begin
		if (en) begin
			x_neg_s6   <= x_neg_s5;
			y_neg_s6   <= y_neg_s5;
			z_neg_s6   <= z_neg_s5;
			z_mag_s6   <= z_mag_s5;
			x_pp_s6[0] <= PP_W'(cl_mag_s5[HALF_W-1:0]) * PP_W'(co_mag_s5[HALF_W-1:0]);
			x_pp_s6[1] <= PP_W'(cl_mag_s5[HALF_W-1:0]) * PP_W'(co_mag_s5[MAG_W-1:HALF_W]);
			x_pp_s6[2] <= PP_W'(cl_mag_s5[MAG_W-1:HALF_W]) * PP_W'(co_mag_s5[HALF_W-1:0]);
			x_pp_s6[3] <= PP_W'(cl_mag_s5[MAG_W-1:HALF_W]) * PP_W'(co_mag_s5[MAG_W-1:HALF_W]);
			y_pp_s6[0] <= PP_W'(cl_mag_s5[HALF_W-1:0]) * PP_W'(so_mag_s5[HALF_W-1:0]);
			y_pp_s6[1] <= PP_W'(cl_mag_s5[HALF_W-1:0]) * PP_W'(so_mag_s5[MAG_W-1:HALF_W]);
			y_pp_s6[2] <= PP_W'(cl_mag_s5[MAG_W-1:HALF_W]) * PP_W'(so_mag_s5[HALF_W-1:0]);
			y_pp_s6[3] <= PP_W'(cl_mag_s5[MAG_W-1:HALF_W]) * PP_W'(so_mag_s5[MAG_W-1:HALF_W]);
		end
	end

	// Stage 7: add the two cross terms.
	always_ff @(posedge clk) begin
		if (en) begin
			x_neg_s7 <= x_neg_s6;
			y_neg_s7 <= y_neg_s6;
			z_neg_s7 <= z_neg_s6;
			z_mag_s7 <= z_mag_s6;
			x_lo_s7  <= x_pp_s6[0];
			x_mid_s7 <= (PP_W+1)'(x_pp_s6[1]) + (PP_W+1)'(x_pp_s6[2]);
			x_hi_s7  <= x_pp_s6[3];
			y_lo_s7  <= y_pp_s6[0];
			y_mid_s7 <= (PP_W+1)'(y_pp_s6[1]) + (PP_W+1)'(y_pp_s6[2]);
			y_hi_s7  <= y_pp_s6[3];
		end
	end

	// Stage 8: full product, truncated back to the working format.
	always_comb begin
		x_full = (PROD_W'(x_hi_s7) << MAG_W) + (PROD_W'(x_mid_s7) << HALF_W) + PROD_W'(x_lo_s7);
		y_full = (PROD_W'(y_hi_s7) << MAG_W) + (PROD_W'(y_mid_s7) << HALF_W) + PROD_W'(y_lo_s7);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_neg_s8 <= x_neg_s7;
			y_neg_s8 <= y_neg_s7;
			z_neg_s8 <= z_neg_s7;
			z_mag_s8 <= z_mag_s7;
			x_mag_s8 <= x_full[WORK_BITS +: WORK_W];
			y_mag_s8 <= y_full[WORK_BITS +: WORK_W];
		end
	end

	// Stage 9: round, saturate and sign the three components.
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s9.vec_x <= to_vec(x_mag_s8, x_neg_s8);
			vec_s9.vec_y <= to_vec(y_mag_s8, y_neg_s8);
			vec_s9.vec_z <= to_vec(z_mag_s8, z_neg_s8);
		end
	end

	// Valid bits for the stages outside the rotator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= angle_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= rot_res.valid;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// Holding register catches a result that is not taken as the pipeline moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (vec_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_s9 && !vec_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_q <= vec_s9;
		end
	end

	// The held result goes out ahead of the last pipeline stage.
	assign vec_valid = skid_vld_q || vld_s9;
	assign vec       = skid_vld_q ? skid_q : vec_s9;

endmodule
